// ----- design/gfmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Galois field multiply/divide package
// Field codes, command codes, table layout and field helper functions shared
// by the channel interfaces and the arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gfmd_pkg;

   // widest supported field and operand width
   localparam int MAX_FIELD_BITS = 16;
   localparam int OPERAND_WIDTH  = 16;

   // field codes as held in the width register
   typedef enum logic [1:0] {
      FIELD_GF4  = 2'd0,
      FIELD_GF8  = 2'd1,
      FIELD_GF16 = 2'd2
   } field_type;

   localparam logic [1:0] FIELD_SELECT_RESET = 2'd1;

   // command codes
   localparam logic CMD_MUL = 1'b0;
   localparam logic CMD_DIV = 1'b1;

   // register map: one register at byte address 0
   localparam int         CSR_ADDR_WIDTH         = 3;
   localparam int         CSR_DATA_WIDTH         = 32;
   localparam logic [0:0] REG_FIELD_WIDTH_SELECT = 1'b0;

   // table layout: GF(2^16) region, then GF(2^8), then GF(2^4)
   localparam int SIZE_GF16      = 65536;
   localparam int SIZE_GF8       = 256;
   localparam int SIZE_GF4       = 16;
   localparam int TAB_DEPTH      = SIZE_GF16 + SIZE_GF8 + SIZE_GF4;
   localparam int TAB_ADDR_WIDTH = $clog2(TAB_DEPTH);

   typedef logic [OPERAND_WIDTH-1:0]  elem_type;
   typedef logic [OPERAND_WIDTH:0]    poly_type;
   typedef logic [TAB_ADDR_WIDTH-1:0] tab_addr_type;

   localparam tab_addr_type BASE_GF16 = TAB_ADDR_WIDTH'(0);
   localparam tab_addr_type BASE_GF8  = TAB_ADDR_WIDTH'(SIZE_GF16);
   localparam tab_addr_type BASE_GF4  = TAB_ADDR_WIDTH'(SIZE_GF16 + SIZE_GF8);

   // primitive polynomials, x^w term included
   localparam poly_type POLY_GF4  = poly_type'(17'o23);
   localparam poly_type POLY_GF8  = poly_type'(17'o435);
   localparam poly_type POLY_GF16 = 17'o210013;

   // map the register value onto a supported field
   function automatic field_type eff_field(input logic [1:0] sel);
      field_type f;
      case (sel)
         2'd0:    f = FIELD_GF4;
         2'd1:    f = FIELD_GF8;
         default: f = FIELD_GF16;
      endcase
      if (f == FIELD_GF16 && MAX_FIELD_BITS < 16) f = FIELD_GF8;
      if (f == FIELD_GF8 && MAX_FIELD_BITS < 8) f = FIELD_GF4;
      return f;
   endfunction

   // element mask, also the multiplicative group order 2^w - 1
   function automatic elem_type field_mask(input field_type f);
      case (f)
         FIELD_GF4: return elem_type'(16'h000F);
         FIELD_GF8: return elem_type'(16'h00FF);
         default:   return elem_type'(16'hFFFF);
      endcase
   endfunction

   function automatic tab_addr_type field_base(input field_type f);
      case (f)
         FIELD_GF4: return BASE_GF4;
         FIELD_GF8: return BASE_GF8;
         default:   return BASE_GF16;
      endcase
   endfunction

   function automatic poly_type field_poly(input field_type f);
      case (f)
         FIELD_GF4: return POLY_GF4;
         FIELD_GF8: return POLY_GF8;
         default:   return POLY_GF16;
      endcase
   endfunction

   // multiply an element by the generator x, reducing by the polynomial
   function automatic elem_type alpha_step(input elem_type x, input field_type f);
      poly_type nx;
      poly_type top;
      nx  = {x, 1'b0};
      top = {1'b0, field_mask(f)} + poly_type'(1);
      if ((nx & top) != '0) nx = nx ^ field_poly(f);
      return nx[OPERAND_WIDTH-1:0] & field_mask(f);
   endfunction

endpackage

`default_nettype wire

// ----- design/gfmd_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the command and the two operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfmd_req_if;
   import gfmd_pkg::*;

   logic     valid;
   logic     ready;
   logic     cmd;
   elem_type operand_a;
   elem_type operand_b;

   modport source (output valid, output cmd, output operand_a, output operand_b,
                   input ready);
   modport sink (input valid, input cmd, input operand_a, input operand_b,
                 output ready);
endinterface

`default_nettype wire

// ----- design/gfmd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the field result and the divide-by-zero flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfmd_rsp_if;
   import gfmd_pkg::*;

   logic     valid;
   logic     ready;
   elem_type field_result;
   logic     divide_by_zero;

   modport source (output valid, output field_result, output divide_by_zero,
                   input ready);
   modport sink (input valid, input field_result, input divide_by_zero,
                 output ready);
endinterface

`default_nettype wire

// ----- design/galois_field_mul_div.sv -----
// A request passes stage 1, stage 2, stage 3 and the output register to the response channel.
// Throughput: one request per cycle unless a fill runs or the response is held; the log memory
// reads both operands on its two read ports and the antilog memory serves one lookup per cycle.
// Reset: the width register returns to GF(2^8) and the log/antilog memories are rebuilt
// by a fill (GF(2^16), GF(2^8), GF(2^4) in turn) during which no request is
// taken; register writes are taken throughout.
// ----------------------------------------------------------------------------
// Galois field multiply/divide unit
// Log/antilog table unit for GF(2^4), GF(2^8) and GF(2^16): two log reads, an
// add or subtract modulo 2^w-1, and an antilog read, in a four-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module galois_field_mul_div (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   gfmd_req_if.sink                                    req_bus,
   gfmd_rsp_if.source                                  rsp_bus,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [gfmd_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [gfmd_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic      [gfmd_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                        csr_pready
);
   import gfmd_pkg::*;

   // width register
   logic [1:0] field_sel_ff;
   logic       csr_write;

   // table fill
   logic         fill_busy_ff;
   field_type    fill_field_ff;
   elem_type     fill_idx_ff;
   elem_type     fill_x_ff;
   logic         fill_last;
   tab_addr_type fill_log_addr;
   tab_addr_type fill_exp_addr;

   // memories
   elem_type log_mem [TAB_DEPTH];
   elem_type exp_mem [TAB_DEPTH];

   // stage 0: accept
   field_type    s0_field;
   elem_type     s0_a;
   elem_type     s0_b;
   tab_addr_type s0_addr_a;
   tab_addr_type s0_addr_b;
   logic         s0_zero_in;
   logic         s0_dz_in;
   logic         en1;

   // stage 1: log data
   logic         s1_valid_ff;
   logic         s1_cmd_ff;
   field_type    s1_field_ff;
   logic         s1_zero_ff;
   logic         s1_dz_ff;
   elem_type     s1_la_ff;
   elem_type     s1_lb_ff;
   elem_type     s2_e_in;
   logic         en2;

   // stage 2: exponent
   logic         s2_valid_ff;
   field_type    s2_field_ff;
   logic         s2_zero_ff;
   logic         s2_dz_ff;
   elem_type     s2_e_ff;
   tab_addr_type s2_addr;
   logic         en3;

   // stage 3: antilog data
   logic         s3_valid_ff;
   field_type    s3_field_ff;
   logic         s3_zero_ff;
   logic         s3_dz_ff;
   elem_type     s3_val_ff;
   logic         en_out;

   // output register
   logic         rsp_valid_ff;
   field_type    rsp_field_ff;
   elem_type     rsp_result_ff;
   logic         rsp_dz_ff;
   elem_type     rsp_result_in;

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_sel_ff <= FIELD_SELECT_RESET;
      end else if (csr_write && csr_paddr[2] == REG_FIELD_WIDTH_SELECT) begin
         field_sel_ff <= csr_pwdata[1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_FIELD_WIDTH_SELECT) csr_prdata[1:0] = field_sel_ff;
   end

   // ------------------------------------------------------------------
   // table fill: walk the powers of the generator, one per cycle
   // ------------------------------------------------------------------
   assign fill_last     = (fill_idx_ff == field_mask(fill_field_ff) - elem_type'(1));
   assign fill_log_addr = field_base(fill_field_ff) + TAB_ADDR_WIDTH'(fill_x_ff);
   assign fill_exp_addr = field_base(fill_field_ff) + TAB_ADDR_WIDTH'(fill_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff  <= 1'b1;
         fill_field_ff <= eff_field(2'(FIELD_GF16));
         fill_idx_ff   <= '0;
         fill_x_ff     <= elem_type'(1);
      end else if (fill_busy_ff) begin
         if (fill_last) begin
            fill_idx_ff <= '0;
            fill_x_ff   <= elem_type'(1);
            case (fill_field_ff)
               FIELD_GF16: fill_field_ff <= FIELD_GF8;
               FIELD_GF8:  fill_field_ff <= FIELD_GF4;
               default:    fill_busy_ff  <= 1'b0;
            endcase
         end else begin
            fill_idx_ff <= fill_idx_ff + elem_type'(1);
            fill_x_ff   <= alpha_step(fill_x_ff, fill_field_ff);
         end
      end
   end

   // ------------------------------------------------------------------
   // pipeline handshake: a stage moves when the next one is free or moving
   // ------------------------------------------------------------------
   assign en_out        = s3_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign en3           = s2_valid_ff && (!s3_valid_ff || en_out);
   assign en2           = s1_valid_ff && (!s2_valid_ff || en3);
   assign req_bus.ready = !fill_busy_ff && (!s1_valid_ff || en2);
   assign en1           = req_bus.valid && req_bus.ready;

   // ------------------------------------------------------------------
   // stage 0: mask operands, form log addresses, sort out zero cases
   // ------------------------------------------------------------------
   assign s0_field  = eff_field(field_sel_ff);
   assign s0_a      = req_bus.operand_a & field_mask(s0_field);
   assign s0_b      = req_bus.operand_b & field_mask(s0_field);
   assign s0_addr_a = field_base(s0_field) + TAB_ADDR_WIDTH'(s0_a);
   assign s0_addr_b = field_base(s0_field) + TAB_ADDR_WIDTH'(s0_b);
   assign s0_zero_in = (s0_a == '0) || (s0_b == '0);
   assign s0_dz_in   = (req_bus.cmd == CMD_DIV) && (s0_a != '0) && (s0_b == '0);

   // log memory: fill write, two registered reads
   always_ff @(posedge clock) begin
      if (fill_busy_ff) begin
         log_mem[fill_log_addr] <= fill_idx_ff;
      end
      if (en1) begin
         s1_la_ff <= log_mem[s0_addr_a];
         s1_lb_ff <= log_mem[s0_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= 1'b1;
      end else if (en2) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_cmd_ff   <= req_bus.cmd;
         s1_field_ff <= s0_field;
         s1_zero_ff  <= s0_zero_in;
         s1_dz_ff    <= s0_dz_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: add or subtract logs modulo 2^w - 1
   // ------------------------------------------------------------------
   always_comb begin
      logic [OPERAND_WIDTH:0] order;
      logic [OPERAND_WIDTH:0] acc;
      order = {1'b0, field_mask(s1_field_ff)};
      if (s1_cmd_ff == CMD_MUL) begin
         acc = {1'b0, s1_la_ff} + {1'b0, s1_lb_ff};
         if (acc >= order) acc = acc - order;
      end else begin
         acc = {1'b0, s1_la_ff} - {1'b0, s1_lb_ff};
         if (acc[OPERAND_WIDTH]) acc = acc + order;
      end
      s2_e_in = acc[OPERAND_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= 1'b1;
      end else if (en3) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_field_ff <= s1_field_ff;
         s2_zero_ff  <= s1_zero_ff;
         s2_dz_ff    <= s1_dz_ff;
         s2_e_ff     <= s2_e_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: antilog lookup
   // ------------------------------------------------------------------
   assign s2_addr = field_base(s2_field_ff) + TAB_ADDR_WIDTH'(s2_e_ff);

   always_ff @(posedge clock) begin
      if (fill_busy_ff) begin
         exp_mem[fill_exp_addr] <= fill_x_ff;
      end
      if (en3) begin
         s3_val_ff <= exp_mem[s2_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= 1'b1;
      end else if (en_out) begin
         s3_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_field_ff <= s2_field_ff;
         s3_zero_ff  <= s2_zero_ff;
         s3_dz_ff    <= s2_dz_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: drop the lookup for zero operands, hold the response
   // ------------------------------------------------------------------
   assign rsp_result_in = s3_zero_ff ? '0 : s3_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_field_ff  <= s3_field_ff;
         rsp_result_ff <= rsp_result_in;
         rsp_dz_ff     <= s3_dz_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.field_result   = rsp_result_ff;
   assign rsp_bus.divide_by_zero = rsp_dz_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
`ifndef SYNTH
   a_dz_result_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dz_ff |-> rsp_result_ff == '0)
      else $error("divide-by-zero response carries a nonzero result");

   a_result_in_field : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_result_ff & ~field_mask(rsp_field_ff)) == '0)
      else $error("response result exceeds the field width");

   a_s1_advances : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_valid_ff |=> s2_valid_ff)
      else $error("request stalled in stage 1 with stage 2 free");

   a_fill_ends_last : assert property (@(posedge clock) disable iff (reset)
      $fell(fill_busy_ff) |-> $past(fill_field_ff) == FIELD_GF4 && $past(fill_last))
      else $error("table fill ended before the last field was written");
`endif

endmodule

`default_nettype wire
